[rtl/core/i2c_rm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_pkg
// Shared types and constants of the I2C register master.
// ----------------------------------------------------------------------------
package i2c_rm_pkg;

	localparam int unsigned TIMEOUT_W = 10;
	localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 10'd800;
	localparam logic [7:0] MSB_MASK = 8'h80;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	// request codes on the input channel
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_WRITE,
		KIND_READ,
		KIND_NONE
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START,
		PH_TX_SLAVE,
		PH_AK_SLAVE,
		PH_TX_REG,
		PH_AK_REG,
		PH_TX_DATA,
		PH_AK_DATA,
		PH_RESTART,
		PH_TX_SLAVE_RD,
		PH_AK_SLAVE_RD,
		PH_RX,
		PH_NACK,
		PH_STOP_OK,
		PH_STOP_FAIL
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic       sda;
		logic [7:0] slave;
		logic [7:0] regaddr;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

endpackage

[rtl/core/i2c_rm_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2c_rm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       sda_in;
	logic [7:0] dev_addr;
	logic [7:0] reg_index;
	logic [7:0] write_data;

	modport source(output valid, req_type, sda_in, dev_addr, reg_index, write_data,
		input ready);
	modport sink(input valid, req_type, sda_in, dev_addr, reg_index, write_data,
		output ready);
	modport mon(input valid, ready, req_type, sda_in, dev_addr, reg_index, write_data);
endinterface

interface i2c_rm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic       ack_ok;
	logic [7:0] read_data;

	modport source(output valid, scl_level, sda_level, busy_res, done_res, ack_ok,
		read_data, input ready);
	modport sink(input valid, scl_level, sda_level, busy_res, done_res, ack_ok,
		read_data, output ready);
	modport mon(input valid, ready, scl_level, sda_level, busy_res, done_res, ack_ok,
		read_data);
endinterface

[rtl/core/i2c_rm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_front
// Accepts request items and classifies them for the bus sequencer.
// ----------------------------------------------------------------------------
module i2c_rm_front (
	i2c_rm_req_if.sink     req_ch,
	output i2c_rm_pkg::push_t push,
	input  logic           push_ready
);

	i2c_rm_pkg::kind_t kind;

	always_comb begin
		unique case (req_ch.req_type)
			i2c_rm_pkg::REQ_TICK:  kind = i2c_rm_pkg::KIND_TICK;
			i2c_rm_pkg::REQ_WRITE: kind = i2c_rm_pkg::KIND_WRITE;
			i2c_rm_pkg::REQ_READ:  kind = i2c_rm_pkg::KIND_READ;
			default:               kind = i2c_rm_pkg::KIND_NONE;
		endcase
	end

	assign req_ch.ready      = push_ready;
	assign push.valid        = req_ch.valid;
	assign push.item.kind    = kind;
	assign push.item.sda     = req_ch.sda_in;
	assign push.item.slave   = req_ch.dev_addr;
	assign push.item.regaddr = req_ch.reg_index;
	assign push.item.data    = req_ch.write_data;

endmodule

[rtl/core/i2c_rm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_queue
// Short FIFO of classified items between front and sequencer.
// ----------------------------------------------------------------------------
module i2c_rm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2c_rm_pkg::push_t     push,
	output logic                  push_ready,
	output logic                  pop_valid,
	output i2c_rm_pkg::item_t     pop_item,
	input  logic                  pop_ready
);

	i2c_rm_pkg::item_t mem_q [i2c_rm_pkg::QUEUE_DEPTH];
	logic [i2c_rm_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [i2c_rm_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [i2c_rm_pkg::QUEUE_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != i2c_rm_pkg::QUEUE_CW'(i2c_rm_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == i2c_rm_pkg::QUEUE_AW'(i2c_rm_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == i2c_rm_pkg::QUEUE_AW'(i2c_rm_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/i2c_rm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_back
// Bus phase sequencer: one item per cycle unless the result register is stalled, registered result stage.
// ----------------------------------------------------------------------------
module i2c_rm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2c_rm_pkg::TIMEOUT_W-1:0]    cfg_wdata,
	input  logic                                pop_valid,
	input  i2c_rm_pkg::item_t                   pop_item,
	output logic                                pop_ready,
	i2c_rm_res_if.source                        res_ch
);

	i2c_rm_pkg::phase_t phase_q, phase_d;
	logic [1:0] sub_q, sub_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [i2c_rm_pkg::TIMEOUT_W-1:0] wait_q, wait_d;
	logic [i2c_rm_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [7:0] slave_q, slave_d;
	logic [7:0] regaddr_q, regaddr_d;
	logic [7:0] data_q, data_d;
	logic is_read_q, is_read_d;
	logic [3:0] bit_inc;
	logic done_d, ok_d;
	logic [7:0] rd_d;
	logic scl_d, sda_d;
	logic fire;

	logic       valid_q;
	logic       scl_q, sda_q, busy_q, done_q, ok_q;
	logic [7:0] rd_q;

	assign pop_ready = !valid_q || res_ch.ready;
	assign fire      = pop_valid && pop_ready;
	assign bit_inc   = bit_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		sub_d     = sub_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		wait_d    = wait_q;
		slave_d   = slave_q;
		regaddr_d = regaddr_q;
		data_d    = data_q;
		is_read_d = is_read_q;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		rd_d      = '0;

		unique case (pop_item.kind) inside
			i2c_rm_pkg::KIND_WRITE, i2c_rm_pkg::KIND_READ: begin
				// commands while busy are dropped
				if (phase_q == i2c_rm_pkg::PH_IDLE) begin
					slave_d   = pop_item.slave;
					regaddr_d = pop_item.regaddr;
					data_d    = pop_item.data;
					is_read_d = (pop_item.kind == i2c_rm_pkg::KIND_READ);
					phase_d   = i2c_rm_pkg::PH_START;
					sub_d     = 2'd0;
					wait_d    = '0;
				end
			end
			i2c_rm_pkg::KIND_TICK: begin
				unique case (phase_q) inside
					i2c_rm_pkg::PH_START: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else begin
							phase_d = i2c_rm_pkg::PH_TX_SLAVE;
							sub_d   = 2'd0;
							bit_d   = '0;
							shift_d = slave_q;
						end
					end
					i2c_rm_pkg::PH_RESTART: begin
						if (sub_q != 2'd2) begin
							sub_d = sub_q + 2'd1;
						end else begin
							phase_d = i2c_rm_pkg::PH_TX_SLAVE_RD;
							sub_d   = 2'd0;
							bit_d   = '0;
							shift_d = slave_q + 8'd1;
						end
					end
					i2c_rm_pkg::PH_TX_SLAVE, i2c_rm_pkg::PH_TX_REG,
					i2c_rm_pkg::PH_TX_DATA, i2c_rm_pkg::PH_TX_SLAVE_RD: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else begin
							shift_d = {shift_q[6:0], 1'b0};
							bit_d   = bit_inc;
							sub_d   = 2'd0;
							if (bit_inc[3]) begin
								bit_d  = '0;
								wait_d = '0;
								unique case (phase_q) inside
									i2c_rm_pkg::PH_TX_SLAVE: phase_d = i2c_rm_pkg::PH_AK_SLAVE;
									i2c_rm_pkg::PH_TX_REG:   phase_d = i2c_rm_pkg::PH_AK_REG;
									i2c_rm_pkg::PH_TX_DATA:  phase_d = i2c_rm_pkg::PH_AK_DATA;
									default:                 phase_d = i2c_rm_pkg::PH_AK_SLAVE_RD;
								endcase
							end
						end
					end
					i2c_rm_pkg::PH_AK_SLAVE, i2c_rm_pkg::PH_AK_REG,
					i2c_rm_pkg::PH_AK_DATA, i2c_rm_pkg::PH_AK_SLAVE_RD: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else if (!pop_item.sda) begin
							wait_d = '0;
							sub_d  = 2'd0;
							unique case (phase_q) inside
								i2c_rm_pkg::PH_AK_SLAVE: begin
									phase_d = i2c_rm_pkg::PH_TX_REG;
									bit_d   = '0;
									shift_d = regaddr_q;
								end
								i2c_rm_pkg::PH_AK_REG: begin
									if (is_read_q) begin
										phase_d = i2c_rm_pkg::PH_RESTART;
									end else begin
										phase_d = i2c_rm_pkg::PH_TX_DATA;
										bit_d   = '0;
										shift_d = data_q;
									end
								end
								i2c_rm_pkg::PH_AK_DATA: begin
									phase_d = i2c_rm_pkg::PH_STOP_OK;
								end
								default: begin
									phase_d = i2c_rm_pkg::PH_RX;
									bit_d   = '0;
									shift_d = '0;
								end
							endcase
						end else if (wait_q < timeout_q) begin
							wait_d = wait_q + 1'b1;
						end else begin
							// no ACK in time: abort with a stop
							wait_d  = '0;
							phase_d = i2c_rm_pkg::PH_STOP_FAIL;
							sub_d   = 2'd0;
						end
					end
					i2c_rm_pkg::PH_RX: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else begin
							shift_d = {shift_q[6:0], pop_item.sda};
							bit_d   = bit_inc;
							sub_d   = 2'd0;
							if (bit_inc[3]) begin
								phase_d = i2c_rm_pkg::PH_NACK;
								bit_d   = '0;
							end
						end
					end
					i2c_rm_pkg::PH_NACK: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else begin
							phase_d = i2c_rm_pkg::PH_STOP_OK;
							sub_d   = 2'd0;
						end
					end
					i2c_rm_pkg::PH_STOP_OK, i2c_rm_pkg::PH_STOP_FAIL: begin
						if (sub_q == 2'd0) begin
							sub_d = 2'd1;
						end else begin
							done_d  = 1'b1;
							ok_d    = (phase_q == i2c_rm_pkg::PH_STOP_OK);
							rd_d    = (ok_d && is_read_q) ? shift_q : 8'd0;
							phase_d = i2c_rm_pkg::PH_IDLE;
							sub_d   = 2'd0;
							bit_d   = '0;
						end
					end
					default: begin
						phase_d = i2c_rm_pkg::PH_IDLE;
						sub_d   = 2'd0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// drive levels of the phase being entered
	always_comb begin
		scl_d = 1'b1;
		sda_d = 1'b1;
		unique case (phase_d) inside
			i2c_rm_pkg::PH_START: begin
				sda_d = (sub_d == 2'd0);
			end
			i2c_rm_pkg::PH_RESTART: begin
				scl_d = (sub_d != 2'd0);
				sda_d = (sub_d != 2'd2);
			end
			i2c_rm_pkg::PH_TX_SLAVE, i2c_rm_pkg::PH_TX_REG,
			i2c_rm_pkg::PH_TX_DATA, i2c_rm_pkg::PH_TX_SLAVE_RD: begin
				scl_d = (sub_d != 2'd0);
				sda_d = ((shift_d & i2c_rm_pkg::MSB_MASK) != 8'd0);
			end
			i2c_rm_pkg::PH_AK_SLAVE, i2c_rm_pkg::PH_AK_REG, i2c_rm_pkg::PH_AK_DATA,
			i2c_rm_pkg::PH_AK_SLAVE_RD, i2c_rm_pkg::PH_RX, i2c_rm_pkg::PH_NACK: begin
				scl_d = (sub_d != 2'd0);
			end
			i2c_rm_pkg::PH_STOP_OK, i2c_rm_pkg::PH_STOP_FAIL: begin
				scl_d = (sub_d != 2'd0);
				sda_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2c_rm_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2c_rm_pkg::PH_IDLE;
			sub_q     <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			wait_q    <= '0;
			slave_q   <= '0;
			regaddr_q <= '0;
			data_q    <= '0;
			is_read_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			sub_q     <= sub_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			slave_q   <= slave_d;
			regaddr_q <= regaddr_d;
			data_q    <= data_d;
			is_read_q <= is_read_d;
		end
	end

	// result register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			scl_q  <= scl_d;
			sda_q  <= sda_d;
			busy_q <= (phase_d != i2c_rm_pkg::PH_IDLE);
			done_q <= done_d;
			ok_q   <= ok_d;
			rd_q   <= rd_d;
		end
	end

	assign res_ch.valid     = valid_q;
	assign res_ch.scl_level = scl_q;
	assign res_ch.sda_level = sda_q;
	assign res_ch.busy_res  = busy_q;
	assign res_ch.done_res  = done_q;
	assign res_ch.ack_ok    = ok_q;
	assign res_ch.read_data = rd_q;

endmodule

[rtl/core/i2c_register_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master
// I2C master for single-register writes and reads, one bus step per tick item.
// ----------------------------------------------------------------------------
// A result passes through the queue and then the result register after its item is accepted.
// Throughput: one item per cycle unless the result register is stalled, set by the phase sequencer.
// The two-entry queue lets the front accept while the result register is stalled.
// Reset: bus released (idle phase), ack_timeout back to 800, queue and result empty.
module i2c_register_master (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [i2c_rm_pkg::TIMEOUT_W-1:0]  cfg_wdata,
	i2c_rm_req_if.sink                        req_ch,
	i2c_rm_res_if.source                      res_ch
);

	i2c_rm_pkg::push_t push;
	logic              push_ready;
	logic              pop_valid;
	i2c_rm_pkg::item_t pop_item;
	logic              pop_ready;

	i2c_rm_front u_front (
		.req_ch     (req_ch),
		.push       (push),
		.push_ready (push_ready)
	);

	i2c_rm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	i2c_rm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready),
		.res_ch     (res_ch)
	);

endmodule

[rtl/core/i2c_rm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_assertions
// Port-level checks on the result channel of the register master.
// ----------------------------------------------------------------------------
module i2c_rm_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       scl_level,
	input logic       sda_level,
	input logic       busy_res,
	input logic       done_res,
	input logic       ack_ok,
	input logic [7:0] read_data
);

	// finishing a transaction leaves the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done with busy still set");

	a_ok_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> !ack_ok)
		else $error("ack_ok without done");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ack_ok |-> read_data == 8'd0)
		else $error("read data on failed or unfinished item");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> scl_level && sda_level)
		else $error("bus driven while idle");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

endmodule

bind i2c_register_master i2c_rm_assertions u_i2c_rm_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_ch.valid),
	.res_ready (res_ch.ready),
	.scl_level (res_ch.scl_level),
	.sda_level (res_ch.sda_level),
	.busy_res  (res_ch.busy_res),
	.done_res  (res_ch.done_res),
	.ack_ok    (res_ch.ack_ok),
	.read_data (res_ch.read_data)
);

[bench/i2c_rm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_checker
// Watches the request, result and configuration ports of the I2C register
// master, predicts the bus levels and status for every accepted item and
// compares them, in order, with the results the block hands out.
// ----------------------------------------------------------------------------
module i2c_rm_checker import i2c_rm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	i2c_rm_req_if.mon            req_ch,
	i2c_rm_res_if.mon            res_ch,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic       ack;
		logic [7:0] rdata;
	} bus_levels_t;

	bus_levels_t bus_levels_q[$];

	// predicted sequencer state
	phase_t               ph;
	logic [1:0]           sub;
	logic [3:0]           bit_cnt;
	logic [7:0]           shreg;
	logic [TIMEOUT_W-1:0] wait_cnt;
	logic [7:0]           slave_byte;
	logic [7:0]           reg_byte;
	logic [7:0]           data_byte;
	logic                 read_mode;
	logic [TIMEOUT_W-1:0] ack_limit;
	int                   mismatches;

	task automatic load_byte(input phase_t next, input logic [7:0] value);
		ph = next;
		sub = 2'd0;
		bit_cnt = 4'd0;
		shreg = value;
	endtask

	task automatic take_ack();
		case (ph)
			PH_AK_SLAVE: load_byte(PH_TX_REG, reg_byte);
			PH_AK_REG: begin
				if (read_mode) begin
					ph = PH_RESTART;
					sub = 2'd0;
				end else begin
					load_byte(PH_TX_DATA, data_byte);
				end
			end
			PH_AK_DATA: begin
				ph = PH_STOP_OK;
				sub = 2'd0;
			end
			default: begin
				ph = PH_RX;
				sub = 2'd0;
				bit_cnt = 4'd0;
				shreg = 8'h00;
			end
		endcase
	endtask

	task automatic advance_bus(input logic [1:0] req, input logic sda, input logic [7:0] sa,
		input logic [7:0] ra, input logic [7:0] wd, output bus_levels_t levels);
		logic done;
		logic ok;
		logic [7:0] rd;
		done = 1'b0;
		ok = 1'b0;
		rd = 8'h00;
		if (req == REQ_WRITE || req == REQ_READ) begin
			// commands only start from idle
			if (ph == PH_IDLE) begin
				slave_byte = sa;
				reg_byte = ra;
				data_byte = wd;
				read_mode = (req == REQ_READ);
				ph = PH_START;
				sub = 2'd0;
				wait_cnt = '0;
			end
		end else if (req == REQ_TICK) begin
			case (ph)
				PH_START: begin
					if (sub == 2'd0) sub = 2'd1;
					else load_byte(PH_TX_SLAVE, slave_byte);
				end
				PH_RESTART: begin
					if (sub < 2'd2) sub = sub + 2'd1;
					else load_byte(PH_TX_SLAVE_RD, slave_byte + 8'd1);
				end
				PH_TX_SLAVE, PH_TX_REG, PH_TX_DATA, PH_TX_SLAVE_RD: begin
					if (sub == 2'd0) begin
						sub = 2'd1;
					end else begin
						shreg = shreg << 1;
						bit_cnt = bit_cnt + 4'd1;
						sub = 2'd0;
						if (bit_cnt >= 4'd8) begin
							case (ph)
								PH_TX_SLAVE: ph = PH_AK_SLAVE;
								PH_TX_REG:   ph = PH_AK_REG;
								PH_TX_DATA:  ph = PH_AK_DATA;
								default:     ph = PH_AK_SLAVE_RD;
							endcase
							bit_cnt = 4'd0;
							wait_cnt = '0;
						end
					end
				end
				PH_AK_SLAVE, PH_AK_REG, PH_AK_DATA, PH_AK_SLAVE_RD: begin
					if (sub == 2'd0) begin
						sub = 2'd1;
					end else if (sda == 1'b0) begin
						wait_cnt = '0;
						take_ack();
					end else if (wait_cnt < ack_limit) begin
						wait_cnt = wait_cnt + 1'b1;
					end else begin
						wait_cnt = '0;
						ph = PH_STOP_FAIL;
						sub = 2'd0;
					end
				end
				PH_RX: begin
					if (sub == 2'd0) begin
						sub = 2'd1;
					end else begin
						shreg = {shreg[6:0], sda};
						bit_cnt = bit_cnt + 4'd1;
						sub = 2'd0;
						if (bit_cnt >= 4'd8) begin
							ph = PH_NACK;
							bit_cnt = 4'd0;
						end
					end
				end
				PH_NACK: begin
					if (sub == 2'd0) begin
						sub = 2'd1;
					end else begin
						ph = PH_STOP_OK;
						sub = 2'd0;
					end
				end
				PH_STOP_OK, PH_STOP_FAIL: begin
					if (sub == 2'd0) begin
						sub = 2'd1;
					end else begin
						done = 1'b1;
						ok = (ph == PH_STOP_OK);
						rd = (ok && read_mode) ? shreg : 8'h00;
						ph = PH_IDLE;
						sub = 2'd0;
						bit_cnt = 4'd0;
					end
				end
				default: begin
					ph = PH_IDLE;
					sub = 2'd0;
				end
			endcase
		end

		// levels now driven, from the phase and its step
		levels.scl = 1'b1;
		levels.sda = 1'b1;
		case (ph)
			PH_START: levels.sda = (sub == 2'd0);
			PH_RESTART: begin
				levels.scl = (sub != 2'd0);
				levels.sda = (sub != 2'd2);
			end
			PH_TX_SLAVE, PH_TX_REG, PH_TX_DATA, PH_TX_SLAVE_RD: begin
				levels.scl = (sub != 2'd0);
				levels.sda = ((shreg & MSB_MASK) != 8'h00);
			end
			PH_AK_SLAVE, PH_AK_REG, PH_AK_DATA, PH_AK_SLAVE_RD, PH_RX, PH_NACK:
				levels.scl = (sub != 2'd0);
			PH_STOP_OK, PH_STOP_FAIL: begin
				levels.scl = (sub != 2'd0);
				levels.sda = 1'b0;
			end
			default: ;
		endcase
		levels.busy = (ph != PH_IDLE);
		levels.done = done;
		levels.ack = ok;
		levels.rdata = rd;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bus_levels_t got;
		bus_levels_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			sub = 2'd0;
			bit_cnt = 4'd0;
			shreg = 8'h00;
			wait_cnt = '0;
			slave_byte = 8'h00;
			reg_byte = 8'h00;
			data_byte = 8'h00;
			read_mode = 1'b0;
			ack_limit = ACK_TIMEOUT_RESET;
			mismatches = 0;
			bus_levels_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.scl_level, res_ch.sda_level, res_ch.busy_res, res_ch.done_res,
					res_ch.ack_ok, res_ch.read_data};
				if (bus_levels_q.size() == 0) begin
					mismatches++;
					$display("%0t: result without an outstanding item:", $time);
					$display("%0t:   scl=%b sda=%b busy=%b done=%b ack=%b data=%h",
						$time, got.scl, got.sda, got.busy, got.done, got.ack, got.rdata);
				end else begin
					want = bus_levels_q.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: mismatch: expected scl=%b sda=%b busy=%b done=%b ack=%b",
							$time, want.scl, want.sda, want.busy, want.done, want.ack);
						$display("%0t:           expected data=%h", $time, want.rdata);
						$display("%0t:           actual scl=%b sda=%b busy=%b done=%b ack=%b",
							$time, got.scl, got.sda, got.busy, got.done, got.ack);
						$display("%0t:           actual data=%h", $time, got.rdata);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				advance_bus(req_ch.req_type, req_ch.sda_in, req_ch.dev_addr, req_ch.reg_index,
					req_ch.write_data, want);
				bus_levels_q.push_back(want);
			end
			if (cfg_we)
				ack_limit = cfg_wdata;
			fail_count <= mismatches;
			pending <= bus_levels_q.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register write and read transfers into the I2C register master,
// playing a slave that acks quickly, acks late or stays silent, across
// several ACK timeouts, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import i2c_rm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASE_COUNT = 6;

	typedef enum int {SLAVE_ACKS, SLAVE_NOISY, SLAVE_ABSENT} slave_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;
	logic [TIMEOUT_W-1:0] cur_timeout;
	logic                 steady;
	int                   fail_count;
	int                   pending;
	int                   done_seen = 0;
	int                   items_sent;
	int                   cycle_count = 0;

	i2c_rm_req_if req_ch();
	i2c_rm_res_if res_ch();

	i2c_register_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_ch    (req_ch),
		.res_ch    (res_ch)
	);

	i2c_rm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_ch     (req_ch),
		.res_ch     (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// count finished transfers so the stimulus knows when the bus is free
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready && res_ch.done_res)
			done_seen <= done_seen + 1;
	end

	always @(negedge clk) begin
		res_ch.ready = steady || ($urandom_range(0, 99) >= 30);
	end

	function automatic logic slave_line(input slave_mode_t mode);
		case (mode)
			SLAVE_ACKS:  return ($urandom_range(0, 99) < 30);
			SLAVE_NOISY: return 1'($urandom_range(0, 1));
			default:     return 1'b1;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] req, input logic sda, input logic [7:0] sa,
		input logic [7:0] ra, input logic [7:0] wd);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 25) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = req;
		req_ch.sda_in = sda;
		req_ch.dev_addr = sa;
		req_ch.reg_index = ra;
		req_ch.write_data = wd;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_noise();
		logic [1:0] req;
		case ($urandom_range(0, 2))
			0:       req = REQ_UNUSED;
			1:       req = REQ_WRITE;
			default: req = REQ_READ;
		endcase
		send_item(req, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// one command, then ticks until its done result shows up
	task automatic run_transfer(input logic [1:0] kind, input logic [7:0] sa, input logic [7:0] ra,
		input logic [7:0] wd, input slave_mode_t mode, input logic noise);
		int seen;
		int ticks;
		seen = done_seen;
		send_item(kind, 1'($urandom_range(0, 1)), sa, ra, wd);
		ticks = 0;
		while (done_seen == seen) begin
			// the shortest transfer is still busy for the first 18 ticks
			if (noise && ticks < 18 && $urandom_range(0, 99) < 4)
				send_noise();
			else
				send_item(REQ_TICK, slave_line(mode), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			ticks++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		cur_timeout = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int phase_start;
		logic [1:0] kind;
		slave_mode_t mode;
		logic [TIMEOUT_W-1:0] value;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cur_timeout = ACK_TIMEOUT_RESET;
		steady = 1'b0;
		items_sent = 0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.sda_in = 1'b1;
		req_ch.dev_addr = 8'h00;
		req_ch.reg_index = 8'h00;
		req_ch.write_data = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle ticks and the unused code leave the bus released
		send_item(REQ_TICK, 1'b0, 8'h00, 8'h00, 8'h00);
		send_item(REQ_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF);
		send_item(REQ_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF);
		run_transfer(REQ_WRITE, 8'hFE, 8'h00, 8'hFF, SLAVE_ACKS, 1'b1);
		run_transfer(REQ_READ, 8'hFF, 8'hFF, 8'h00, SLAVE_ACKS, 1'b1);
		run_transfer(REQ_WRITE, 8'h00, 8'hFF, 8'h00, SLAVE_NOISY, 1'b0);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_drained();
			case (p)
				0:       value = '0;
				1:       value = 10'd1023;
				2:       value = 10'd1;
				3:       value = 10'd3;
				4:       value = TIMEOUT_W'($urandom_range(4, 1022));
				default: value = ACK_TIMEOUT_RESET;
			endcase
			write_timeout(value);
			steady = (p == 1);
			phase_start = items_sent;
			// a silent slave runs out the full timeout once at each extreme
			if (p <= 1)
				run_transfer(p == 0 ? REQ_READ : REQ_WRITE, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), SLAVE_ABSENT,
					1'b0);
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15)
					repeat ($urandom_range(1, 2)) begin
						if ($urandom_range(0, 1))
							send_item(REQ_UNUSED, 1'($urandom_range(0, 1)),
								8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
								8'($urandom_range(0, 255)));
						else
							send_item(REQ_TICK, 1'($urandom_range(0, 1)),
								8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
								8'($urandom_range(0, 255)));
					end
				kind = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
				case ($urandom_range(0, 9))
					0, 1:    mode = SLAVE_NOISY;
					2:       mode = (cur_timeout <= 10'd3) ? SLAVE_ABSENT : SLAVE_ACKS;
					default: mode = SLAVE_ACKS;
				endcase
				run_transfer(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), mode, 1'b1);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
